// ----- rtl/core/ordered_array_list_table_top_macros.svh -----
// Assertion macros shared by the ordered array list table RTL.
`ifndef ORDERED_ARRAY_LIST_TABLE_TOP_MACROS_SVH
`define ORDERED_ARRAY_LIST_TABLE_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OAL_ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that, once seen, implies another one at the next edge.
`define OAL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/oal_pkg.sv -----
// Package with sizes, codes and types of the ordered array list table.
package oal_pkg;

	localparam int DEPTH  = 64;
	localparam int ELEM_W = 32;
	localparam int OP_W   = 2;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WIDE_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_POSITION = 2'd1,
		ST_FULL     = 2'd2
	} result_code_t;

endpackage

// ----- rtl/core/oal_req_if.sv -----
// Request channel of the ordered array list table.
interface oal_req_if import oal_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, operation, position, value, input ready);
	modport sink (input valid, operation, position, value, output ready);
endinterface

// ----- rtl/core/oal_rsp_if.sv -----
// Result channel of the ordered array list table.
interface oal_rsp_if import oal_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] removed_value;
	logic [POS_W-1:0]        found_position;
	logic [POS_W-1:0]        list_length;

	modport source (output valid, status, removed_value, found_position, list_length,
		input ready);
	modport sink (input valid, status, removed_value, found_position, list_length,
		output ready);
endinterface

// ----- rtl/core/ordered_array_list_table_top.sv -----
// Ordered array list table: a fixed-capacity list with insert, delete and locate.
//
// Each request on req carries an operation, a 1-based position and a value. Insert
// places the value before the position, delete removes the entry at the position and
// returns it, locate returns the first matching position or zero. Each request yields
// exactly one result on rsp with a status and the list length after the operation.
// The entries live in a single-port-write, single-port-read memory, and one sequencer
// walks it moving or comparing one entry per cycle. An insert moves the entries from
// the last one down to position p up by one and then writes the value, or writes it at
// once when it appends; a delete moves the entries after p down by one; a locate reads
// from the first entry until a match or the end; locates on an empty list, rejected and
// unused requests go straight to the result. req.ready is high only while the
// sequencer is idle, from the cycle after the result is loaded.
// A finished result waits in the output register; the next request may be accepted
// meanwhile, and its result is held in the sequencer until rsp.ready frees the
// register. Reset empties the list and drops any pending result; memory contents need
// no clearing.
`include "ordered_array_list_table_top_macros.svh"

module ordered_array_list_table_top import oal_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	oal_req_if.sink   req,
	oal_rsp_if.source rsp
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_WRVAL, S_DONE} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [ELEM_W-1:0]   val_q;
	logic [ADDR_W-1:0]   rd_idx_q;
	logic [ADDR_W-1:0]   prev_idx_q;
	logic [ADDR_W-1:0]   first_idx_q;
	logic [ADDR_W-1:0]   last_idx_q;
	logic                rd_done_q;
	logic                pend_q;
	result_code_t        status_q;
	logic [ELEM_W-1:0]   removed_q;
	logic [POS_W-1:0]    found_q;
	logic [CNT_W-1:0]    new_cnt_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                rsp_valid_q;
	result_code_t        rsp_status_q;
	logic [ELEM_W-1:0]   rsp_removed_q;
	logic [POS_W-1:0]    rsp_found_q;
	logic [POS_W-1:0]    rsp_len_q;

	logic [ELEM_W-1:0]   mem [DEPTH];
	logic [ELEM_W-1:0]   rdata_q;
	logic                we;
	logic [ADDR_W-1:0]   wa;
	logic [ELEM_W-1:0]   wd;

	logic [WIDE_W-1:0]   pos_w;
	logic [WIDE_W-1:0]   cnt_w;
	logic [ADDR_W-1:0]   pos_idx;
	logic [ADDR_W-1:0]   cnt_m1;
	logic                ins_bad;
	logic                del_bad;
	logic                full;
	logic                req_fire;
	logic                issue;

	assign req.ready   = (state_q == S_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign issue       = (state_q == S_RUN) && !rd_done_q;

	assign pos_w   = WIDE_W'(req.position);
	assign cnt_w   = WIDE_W'(cnt_q);
	assign pos_idx = ADDR_W'(req.position - POS_W'(1));
	assign cnt_m1  = ADDR_W'(cnt_q - CNT_W'(1));
	assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + WIDE_W'(1));
	assign del_bad = (pos_w == '0) || (pos_w > cnt_w);
	assign full    = (cnt_q == CNT_W'(DEPTH));

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.removed_value  = VAL_W'(rsp_removed_q);
	assign rsp.found_position = rsp_found_q;
	assign rsp.list_length    = rsp_len_q;

	always_comb begin
		we = 1'b0;
		wa = prev_idx_q;
		wd = rdata_q;
		if (state_q == S_WRVAL) begin
			we = 1'b1;
			wa = first_idx_q;
			wd = val_q;
		end else if (state_q == S_RUN && pend_q) begin
			if (op_q == OP_INSERT) begin
				we = 1'b1;
				wa = prev_idx_q + ADDR_W'(1);
			end else if (op_q == OP_DELETE && prev_idx_q != first_idx_q) begin
				we = 1'b1;
				wa = prev_idx_q - ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rd_done_q   <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q        <= op_t'(req.operation);
						val_q       <= ELEM_W'(unsigned'(req.value));
						status_q    <= ST_OK;
						removed_q   <= '0;
						found_q     <= '0;
						new_cnt_q   <= cnt_q;
						rd_done_q   <= 1'b0;
						pend_q      <= 1'b0;
						first_idx_q <= pos_idx;
						state_q     <= S_DONE;
						if (req.operation == OP_INSERT) begin
							if (ins_bad) begin
								status_q <= ST_POSITION;
							end else if (full) begin
								status_q <= ST_FULL;
							end else begin
								new_cnt_q <= cnt_q + CNT_W'(1);
								rd_idx_q  <= cnt_m1;
								last_idx_q <= pos_idx;
								state_q   <= (pos_w == cnt_w + WIDE_W'(1)) ? S_WRVAL : S_RUN;
							end
						end else if (req.operation == OP_DELETE) begin
							if (del_bad) begin
								status_q <= ST_POSITION;
							end else begin
								new_cnt_q  <= cnt_q - CNT_W'(1);
								rd_idx_q   <= pos_idx;
								last_idx_q <= cnt_m1;
								state_q    <= S_RUN;
							end
						end else if (req.operation == OP_LOCATE) begin
							if (cnt_q != '0) begin
								rd_idx_q   <= '0;
								last_idx_q <= cnt_m1;
								state_q    <= S_RUN;
							end
						end
					end
				end
				S_RUN: begin
					pend_q <= issue;
					if (issue) begin
						prev_idx_q <= rd_idx_q;
						if (rd_idx_q == last_idx_q) begin
							rd_done_q <= 1'b1;
						end else if (op_q == OP_INSERT) begin
							rd_idx_q <= rd_idx_q - ADDR_W'(1);
						end else begin
							rd_idx_q <= rd_idx_q + ADDR_W'(1);
						end
					end
					if (pend_q) begin
						if (op_q == OP_DELETE && prev_idx_q == first_idx_q) begin
							removed_q <= rdata_q;
						end
						if (op_q == OP_LOCATE && rdata_q == val_q) begin
							found_q <= POS_W'(CNT_W'(prev_idx_q) + CNT_W'(1));
							state_q <= S_DONE;
						end else if (prev_idx_q == last_idx_q) begin
							state_q <= (op_q == OP_INSERT) ? S_WRVAL : S_DONE;
						end
					end
				end
				S_WRVAL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_status_q  <= status_q;
						rsp_removed_q <= removed_q;
						rsp_found_q   <= found_q;
						rsp_len_q     <= POS_W'(new_cnt_q);
						cnt_q         <= new_cnt_q;
						state_q       <= S_IDLE;
					end
				end
			endcase
		end
	end

	`OAL_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count exceeds capacity")
	`OAL_ASSERT_ALWAYS(a_full_len, !(rsp_valid_q && rsp_status_q == ST_FULL) || full, "false full")
	`OAL_ASSERT_ALWAYS(a_len_match, !rsp_valid_q || rsp_len_q == POS_W'(cnt_q), "length mismatch")
	`OAL_ASSERT_NEXT(a_cnt_hold, state_q != S_DONE, $stable(cnt_q), "count changed early")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the ordered array list table, with a shadow list that predicts every result.
`timescale 1ns / 1ps

import oal_pkg::*;

typedef struct {
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] removed_value;
	logic [POS_W-1:0]        found_position;
	logic [POS_W-1:0]        list_length;
} list_result_t;

class list_scoreboard;
	logic signed [ELEM_W-1:0] entries [DEPTH];
	int                       count;
	list_result_t             awaited[$];
	int unsigned              errors;

	function new();
		count = 0;
		errors = 0;
	endfunction

	// An accepted request updates the shadow list and queues the result it must produce.
	function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
		logic signed [VAL_W-1:0] val);
		list_result_t r;
		int           p;
		p = int'(pos);
		r.status = ST_OK;
		r.removed_value = '0;
		r.found_position = '0;
		case (op)
		OP_INSERT: begin
			if (p < 1 || p > count + 1) begin
				r.status = ST_POSITION;
			end else if (count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				for (int i = count; i >= p; i--) begin
					entries[i] = entries[i - 1];
				end
				entries[p - 1] = val;
				count++;
			end
		end
		OP_DELETE: begin
			if (p < 1 || p > count) begin
				r.status = ST_POSITION;
			end else begin
				r.removed_value = entries[p - 1];
				for (int i = p; i < count; i++) begin
					entries[i - 1] = entries[i];
				end
				count--;
			end
		end
		OP_LOCATE: begin
			for (int i = 0; i < count; i++) begin
				if (entries[i] == val && r.found_position == 0) begin
					r.found_position = POS_W'(i + 1);
				end
			end
		end
		default: begin
		end
		endcase
		r.list_length = POS_W'(count);
		awaited.push_back(r);
	endfunction

	function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(list_result_t got);
		list_result_t want;
		if (awaited.size() == 0) begin
			$display("%0t: result with status %0d arrived with no request outstanding",
				$time, got.status);
			errors++;
			return;
		end
		want = awaited.pop_front();
		compare_field("status", VAL_W'(want.status), VAL_W'(got.status));
		compare_field("removed_value", want.removed_value, got.removed_value);
		compare_field("found_position", VAL_W'(want.found_position),
			VAL_W'(got.found_position));
		compare_field("list_length", VAL_W'(want.list_length), VAL_W'(got.list_length));
	endfunction
endclass

module tb_top;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int REQUEST_TARGET = 1400;
	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_AFTER = 150;

	typedef enum int {GROW, SHRINK, MIXED} trend_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_t;

	logic clk;
	logic arst_n;

	oal_req_if req ();
	oal_rsp_if rsp ();

	ordered_array_list_table_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	list_scoreboard          board;
	trend_t                  trend;
	rx_mode_t                rx_mode;
	logic signed [VAL_W-1:0] value_pool [6];
	logic [OP_W-1:0]         op;
	logic [POS_W-1:0]        pos;
	logic signed [VAL_W-1:0] val;
	list_result_t            got;
	int                      burst_left;
	int                      sent;
	int                      results_seen;
	int                      hold_left;
	int                      seg_left;
	int                      idle_cycles;
	bit                      hold_done;
	logic                    ready_next;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 4) begin
			return value_pool[$urandom_range(0, 5)];
		end
		return $urandom;
	endfunction

	task automatic pick_request(output logic [OP_W-1:0] o, output logic [POS_W-1:0] p,
		output logic signed [VAL_W-1:0] v);
		int roll;
		int n;
		int ins_pct;
		int del_pct;
		n = board.count;
		case (trend)
		GROW: begin
			if (n == DEPTH && $urandom_range(0, 11) == 0) begin
				trend = SHRINK;
			end
		end
		SHRINK: begin
			if (n == 0 && $urandom_range(0, 3) == 0) begin
				trend = ($urandom_range(0, 2) == 0) ? MIXED : GROW;
			end
		end
		default: begin
			if ($urandom_range(0, 59) == 0) begin
				trend = GROW;
			end
		end
		endcase
		ins_pct = (trend == GROW) ? 65 : (trend == SHRINK) ? 12 : 33;
		del_pct = (trend == GROW) ? 12 : (trend == SHRINK) ? 65 : 33;
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			o = OP_UNUSED;
		end else if (roll < 3 + ins_pct) begin
			o = OP_INSERT;
		end else if (roll < 3 + ins_pct + del_pct) begin
			o = OP_DELETE;
		end else begin
			o = OP_LOCATE;
		end
		p = POS_W'($urandom_range(0, 127));
		v = pick_value();
		if (o == OP_INSERT && $urandom_range(0, 99) < 88) begin
			p = POS_W'($urandom_range(1, n + 1));
		end else if (o == OP_DELETE && n > 0 && $urandom_range(0, 99) < 88) begin
			p = POS_W'($urandom_range(1, n));
		end else if (o == OP_LOCATE && n > 0 && $urandom_range(0, 1) == 0) begin
			v = board.entries[$urandom_range(0, n - 1)];
		end
	endtask

	// The sender offers requests in bursts and pauses for a random gap between them.
	task automatic send_request(input logic [OP_W-1:0] o, input logic [POS_W-1:0] p,
		input logic signed [VAL_W-1:0] v);
		req.valid <= 1'b1;
		req.operation <= o;
		req.position <= p;
		req.value <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		board.note_request(o, p, v);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.operation <= '0;
		req.position <= '0;
		req.value <= '0;
		board = new();
		trend = GROW;
		burst_left = $urandom_range(0, 12);
		value_pool[0] = '0;
		value_pool[1] = -1;
		value_pool[2] = 32'sh8000_0000;
		value_pool[3] = 32'sh7FFF_FFFF;
		value_pool[4] = $urandom;
		value_pool[5] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_DELETE, 7'd1, 32'sd5);
		send_request(OP_LOCATE, 7'd0, 32'sd0);
		send_request(OP_INSERT, 7'd0, 32'sd9);
		send_request(OP_INSERT, 7'd2, 32'sd9);
		send_request(OP_INSERT, 7'd1, 32'sh7FFF_FFFF);
		send_request(OP_INSERT, 7'd1, 32'sh8000_0000);
		send_request(OP_INSERT, 7'd3, 32'sd0);
		send_request(OP_INSERT, 7'd127, -32'sd1);
		send_request(OP_LOCATE, 7'd127, 32'sh8000_0000);
		send_request(OP_LOCATE, 7'd0, 32'sh7FFF_FFFF);
		send_request(OP_LOCATE, 7'd5, -32'sd1);
		send_request(OP_UNUSED, 7'd127, -32'sd1);
		send_request(OP_INSERT, 7'd2, 32'sd0);
		send_request(OP_LOCATE, 7'd1, 32'sd0);
		send_request(OP_DELETE, 7'd127, 32'sd0);
		send_request(OP_DELETE, 7'd0, 32'sd0);
		send_request(OP_DELETE, 7'd4, 32'sd0);
		send_request(OP_DELETE, 7'd1, 32'sd0);
		send_request(OP_DELETE, 7'd1, -32'sd1);
		send_request(OP_DELETE, 7'd1, 32'sd0);
		send_request(OP_DELETE, 7'd1, 32'sd0);

		sent = 0;
		while (sent < REQUEST_TARGET) begin
			pick_request(op, pos, val);
			send_request(op, pos, val);
			if (op != OP_UNUSED) begin
				sent++;
			end
		end
		req.valid <= 1'b0;

		while (board.awaited.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (board.errors == 0 && board.awaited.size() == 0) begin
			$display("ordered_array_list_table_top: match");
		end else begin
			$display("ordered_array_list_table_top: mismatch");
		end
		$finish;
	end

	// The receiver stalls on its own pattern, with one long hold-off that backs up the results.
	initial begin
		rsp.ready <= 1'b0;
		results_seen = 0;
		hold_left = 0;
		hold_done = 1'b0;
		seg_left = 0;
		rx_mode = RX_OPEN;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				got.status = rsp.status;
				got.removed_value = rsp.removed_value;
				got.found_position = rsp.found_position;
				got.list_length = rsp.list_length;
				board.check_result(got);
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				ready_next = 1'b0;
			end else begin
				if (seg_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 150);
				end
				seg_left--;
				case (rx_mode)
				RX_OPEN: ready_next = 1'b1;
				RX_COIN: ready_next = 1'($urandom_range(0, 1));
				RX_EVERY_FOURTH: ready_next = (seg_left % 4 == 0);
				default: ready_next = ($urandom_range(0, 9) != 0);
				endcase
			end
			rsp.ready <= ready_next;
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("ordered_array_list_table_top: mismatch");
		$finish;
	end
endmodule
